// ===== design/scas_pkg.sv =====
// Shared constants and handshake structs for the self-calibrating axis scaler.
package scas_pkg;

    // Width of every configuration register and of the scaled value.
    localparam int CFG_BITS = 8;
    // Width of the signed displacement result.
    localparam int DISP_BITS = 9;
    // Width of the configuration register index.
    localparam int CFG_IDX_BITS = 2;
    // Step counter width for the eight-step serial multiply and divide.
    localparam int STEP_BITS = $clog2(CFG_BITS);

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_OUT_RANGE   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEAD_BAND   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_REST_CENTER = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CFG_BITS-1:0] RST_OUT_RANGE   = 8'd12;
    localparam logic [CFG_BITS-1:0] RST_DEAD_BAND   = 8'd3;
    localparam logic [CFG_BITS-1:0] RST_REST_CENTER = 8'd6;

    // Control from the sequencer to the serial multiply/divide unit.
    typedef struct packed {
        logic start;
    } t_md_ctrl;

    // Status from the serial multiply/divide unit back to the sequencer.
    typedef struct packed {
        logic done;
    } t_md_stat;

endpackage

// ===== design/self_calibrating_axis_scaler.sv =====
// Top level of the self-calibrating axis scaler with dead band.
// Each input beat carries an axis number and a raw sample. The block widens
// that axis's stored minimum and maximum to include the sample, scales the
// sample onto 0..out_range as (sample - min) * out_range / (max - min) with
// truncation (zero when max equals min), and returns the signed offset from
// rest_center, zeroed within dead_band and negated for axis 1. One item is
// worked at a time, from acceptance to the result beat: take the beat,
// update calibration, eight shift-add multiply steps and eight restoring
// divide steps in the serial scaling unit, then finish and load the output
// register. A new beat is taken in the cycle after the result is loaded,
// even while that result still waits downstream. Configuration must be
// written through the plain write port only while the block is idle; the
// block itself does not enforce this. out_range, dead_band and rest_center
// sit at indexes 0, 1 and 2.
module self_calibrating_axis_scaler import scas_pkg::*; #(
    parameter int SAMPLE_BITS = 10,
    parameter int NUM_AXES    = 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_axis_select,
    input  logic [SAMPLE_BITS-1:0]  i_sample,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [DISP_BITS-1:0] o_displacement,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]     i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CAL,
        ST_CALC,
        ST_DONE
    } t_state;

    t_state                      r_state;
    logic                        r_out_valid;
    logic signed [DISP_BITS-1:0] r_disp;
    logic                        r_axis;
    logic [SAMPLE_BITS-1:0]      r_sample;
    logic [CFG_BITS-1:0]         r_out_range;
    logic [CFG_BITS-1:0]         r_dead_band;
    logic [CFG_BITS-1:0]         r_rest_center;

    logic                        w_axis_ok;
    logic [SAMPLE_BITS-1:0]      w_lo;
    logic [SAMPLE_BITS-1:0]      w_hi;
    t_md_ctrl                    w_md_ctrl;
    t_md_stat                    w_md_stat;
    logic [CFG_BITS-1:0]         w_scaled;
    logic signed [DISP_BITS:0]   n_diff;
    logic signed [DISP_BITS:0]   n_mag;
    logic signed [DISP_BITS:0]   n_kept;
    logic signed [DISP_BITS:0]   n_res;
    logic                        n_in_take;
    logic                        n_out_load;

    // Axis numbers past the configured count leave state alone and give zero.
    assign w_axis_ok = (int'(r_axis) < NUM_AXES);

    assign n_in_take  = i_in_valid && (r_state == ST_IDLE);
    assign n_out_load = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_range   <= RST_OUT_RANGE;
            r_dead_band   <= RST_DEAD_BAND;
            r_rest_center <= RST_REST_CENTER;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_OUT_RANGE:   r_out_range   <= i_cfg_data;
                REG_DEAD_BAND:   r_dead_band   <= i_cfg_data;
                REG_REST_CENTER: r_rest_center <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Calibration store.
    scas_calib #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .NUM_AXES    (NUM_AXES)
    ) u_calib (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update ((r_state == ST_CAL) && w_axis_ok),
        .i_axis   (r_axis),
        .i_sample (r_sample),
        .o_lo     (w_lo),
        .o_hi     (w_hi)
    );

    // Serial scaling unit.
    assign w_md_ctrl.start = (r_state == ST_CAL);

    scas_muldiv #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_muldiv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_md_ctrl),
        .i_sample    (r_sample),
        .i_lo        (w_lo),
        .i_hi        (w_hi),
        .i_out_range (r_out_range),
        .o_stat      (w_md_stat),
        .o_quotient  (w_scaled)
    );

    // Dead band around the rest center, then the inversion for axis 1.
    always_comb begin
        n_diff = $signed({2'b00, w_scaled}) - $signed({2'b00, r_rest_center});
        n_mag  = (n_diff < 0) ? -n_diff : n_diff;
        n_kept = (n_mag > $signed({2'b00, r_dead_band})) ? n_diff : '0;
        if (!w_axis_ok) begin
            n_res = '0;
        end else if (r_axis) begin
            n_res = -n_kept;
        end else begin
            n_res = n_kept;
        end
    end

    // Item sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (n_out_load) begin
                r_out_valid <= 1'b1;
                r_disp      <= n_res[DISP_BITS-1:0];
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (n_in_take) begin
                        r_axis   <= i_axis_select;
                        r_sample <= i_sample;
                        r_state  <= ST_CAL;
                    end
                end
                ST_CAL: begin
                    r_state <= ST_CALC;
                end
                ST_CALC: begin
                    if (w_md_stat.done) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (n_out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_displacement = r_disp;

endmodule

// ===== design/scas_calib.sv =====
// Per-axis running minimum and maximum tracking for the axis scaler.
module scas_calib import scas_pkg::*; #(
    parameter int SAMPLE_BITS = 10,
    parameter int NUM_AXES    = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_update,
    input  logic                   i_axis,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic [SAMPLE_BITS-1:0] o_lo,
    output logic [SAMPLE_BITS-1:0] o_hi
);

    logic [SAMPLE_BITS-1:0] r_min [NUM_AXES];
    logic [SAMPLE_BITS-1:0] r_max [NUM_AXES];
    logic [NUM_AXES-1:0]    w_sel;
    logic [SAMPLE_BITS-1:0] w_cur_lo;
    logic [SAMPLE_BITS-1:0] w_cur_hi;

    // Decode the axis and pick its current calibration pair.
    always_comb begin
        w_cur_lo = '1;
        w_cur_hi = '0;
        for (int k = 0; k < NUM_AXES; k++) begin
            w_sel[k] = (int'(i_axis) == k);
            if (w_sel[k]) begin
                w_cur_lo = r_min[k];
                w_cur_hi = r_max[k];
            end
        end
    end

    // The bounds are widened so that they include the new sample.
    assign o_lo = (i_sample < w_cur_lo) ? i_sample : w_cur_lo;
    assign o_hi = (i_sample > w_cur_hi) ? i_sample : w_cur_hi;

    // Store the widened bounds for the selected axis.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_min[k] <= '1;
                r_max[k] <= '0;
            end
        end else if (i_update) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                if (w_sel[k]) begin
                    r_min[k] <= o_lo;
                    r_max[k] <= o_hi;
                end
            end
        end
    end

endmodule

// ===== design/scas_muldiv.sv =====
// Bit-serial scaling unit: shift-add multiply by out_range, then restoring divide.
module scas_muldiv import scas_pkg::*; #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_md_ctrl               i_ctrl,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [SAMPLE_BITS-1:0] i_lo,
    input  logic [SAMPLE_BITS-1:0] i_hi,
    input  logic [CFG_BITS-1:0]    i_out_range,
    output t_md_stat               o_stat,
    output logic [CFG_BITS-1:0]    o_quotient
);

    localparam int PROD_BITS = SAMPLE_BITS + CFG_BITS;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } t_md_state;

    t_md_state              r_state;
    logic [STEP_BITS-1:0]   r_step;
    logic                   r_done;
    logic                   r_flat;
    logic [SAMPLE_BITS-1:0] r_a;
    logic [SAMPLE_BITS-1:0] r_d;
    logic [CFG_BITS-1:0]    r_mul_sr;
    logic [PROD_BITS-1:0]   r_prod;
    logic [SAMPLE_BITS-1:0] r_rem;
    logic [CFG_BITS-1:0]    r_num_sr;
    logic [CFG_BITS-1:0]    r_quot;

    logic [PROD_BITS-1:0]   n_prod;
    logic [SAMPLE_BITS:0]   n_trial;
    logic [SAMPLE_BITS:0]   n_diff;
    logic                   n_ge;
    logic                   n_last;

    // One multiply step: shift the product and add the offset if the range bit is set.
    assign n_prod = {r_prod[PROD_BITS-2:0], 1'b0}
                  + (r_mul_sr[CFG_BITS-1] ? {{CFG_BITS{1'b0}}, r_a} : '0);

    // One divide step: bring down the next numerator bit and try the subtraction.
    assign n_trial = {r_rem, r_num_sr[CFG_BITS-1]};
    assign n_diff  = n_trial - {1'b0, r_d};
    assign n_ge    = (n_trial >= {1'b0, r_d});
    assign n_last  = (r_step == STEP_BITS'(CFG_BITS - 1));

    // Sequencer for the two serial phases.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_step  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                MD_IDLE: begin
                    if (i_ctrl.start) begin
                        r_a      <= i_sample - i_lo;
                        r_d      <= i_hi - i_lo;
                        r_flat   <= (i_hi == i_lo);
                        r_mul_sr <= i_out_range;
                        r_prod   <= '0;
                        r_step   <= '0;
                        r_state  <= MD_MUL;
                    end
                end
                MD_MUL: begin
                    r_prod   <= n_prod;
                    r_mul_sr <= {r_mul_sr[CFG_BITS-2:0], 1'b0};
                    r_step   <= r_step + STEP_BITS'(1);
                    if (n_last) begin
                        // The quotient fits in eight bits, so the upper product bits
                        // already lie below the divisor.
                        r_rem    <= n_prod[PROD_BITS-1:CFG_BITS];
                        r_num_sr <= n_prod[CFG_BITS-1:0];
                        r_state  <= MD_DIV;
                    end
                end
                MD_DIV: begin
                    r_rem    <= n_ge ? n_diff[SAMPLE_BITS-1:0] : n_trial[SAMPLE_BITS-1:0];
                    r_quot   <= {r_quot[CFG_BITS-2:0], n_ge};
                    r_num_sr <= {r_num_sr[CFG_BITS-2:0], 1'b0};
                    r_step   <= r_step + STEP_BITS'(1);
                    if (n_last) begin
                        r_done  <= 1'b1;
                        r_state <= MD_IDLE;
                    end
                end
                default: begin
                    r_state <= MD_IDLE;
                end
            endcase
        end
    end

    // A flat calibration maps every sample to zero.
    assign o_quotient  = r_flat ? '0 : r_quot;
    assign o_stat.done = r_done;

endmodule

// ===== design/scas_checker.sv =====
// Port-level assertions for the axis scaler and their bind to the top level.
module scas_checker import scas_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [DISP_BITS-1:0] o_displacement
);

    // A result beat waiting on a stalled receiver stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Only one item is in work: a taken beat closes the input.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input open right after a beat was taken");

    // The serial scaling lies between a take and its result, so no result appears right after a take.
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("result appeared one cycle after the input beat");

    // The displacement never reaches the most negative code.
    a_disp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_displacement != {1'b1, {(DISP_BITS-1){1'b0}}})
        else $error("displacement out of range");

endmodule

bind self_calibrating_axis_scaler scas_checker u_scas_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_displacement (o_displacement)
);
